// ===== rtl/frm_pkg.sv =====
// frm_pkg: types and constants for the flow rate meter
// used by rtl/flow_rate_meter.sv, no dependencies of its own
package frm_pkg;

  localparam int FLOW_SLOTS_DEF    = 1024;
  localparam int HISTORY_DEPTH_DEF = 40;

  localparam logic [1:0] OP_PACKET = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_EXISTING = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_FILTERED = 3'd3;
  localparam logic [2:0] ST_TICK     = 3'd4;
  localparam logic [2:0] ST_READ_OK  = 3'd5;
  localparam logic [2:0] ST_UNUSED   = 3'd6;

  localparam logic REG_FILTER_ON  = 1'b0;
  localparam logic REG_LOCAL_ADDR = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_second;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
    logic [15:0] pkt_length;
    logic [9:0]  flow_slot;
    logic [5:0]  window;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [63:0] byte_count;
    logic [63:0] pkt_count;
    logic [34:0] rate_now_bps;
    logic [34:0] rate_peak_bps;
    logic [34:0] avg_rate_bps;
    logic [31:0] seen_sec;
  } out_t;

endpackage

// ===== rtl/flow_rate_meter.sv =====
// flow_rate_meter: five-tuple flow table with per-second rate history, uses frm_pkg
// table scans use one record port; the restoring divide is skipped for an empty
// window; the next item is taken in the cycle after the result is registered, which
// waits while out_ready holds the output back; reset clears the sequencer, the
// output valid, the used slot count, filter_on and local_addr; no clearing pass
module flow_rate_meter #(
  parameter int FLOW_SLOTS    = frm_pkg::FLOW_SLOTS_DEF,
  parameter int HISTORY_DEPTH = frm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  frm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output frm_pkg::out_t out_data
);

  localparam int SLOT_W = $clog2(FLOW_SLOTS);
  localparam int USED_W = SLOT_W + 1;
  localparam int HIST_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int DVD_W  = SUM_W + 3;
  localparam int DCNT_W = $clog2(DVD_W + 1);
  localparam int CMP_W  = ((USED_W > 10) ? USED_W : 10) + 1;
  localparam int HADDR_W = SLOT_W + HIST_W;

  typedef struct packed {
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [39:0]       pp;
    logic [63:0]       bytes;
    logic [63:0]       pkts;
    logic [34:0]       peak;
    logic [31:0]       secb;
    logic [HIST_W-1:0] pos;
    logic [CNT_W-1:0]  fill;
    logic [31:0]       open_sec;
    logic [31:0]       last;
  } rec_t;

  typedef enum logic [3:0] {
    IDLE, SRCH_RD, SRCH_EV, ALLOC, UPD, TICK_RD, TICK_EV, READ_RD, READ_EV,
    RPT_SET, HIST_RD, HIST_EV, DIV_SET, DIV, FIN
  } state_t;

  state_t            state;
  frm_pkg::in_t      in_q;
  logic              filter_on;
  logic [31:0]       local_addr;
  logic [USED_W-1:0] used_slots;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] min_slot;
  logic [31:0]       min_last;
  rec_t              rec;
  logic [2:0]        status;
  logic              stats_on;
  logic [HIST_W-1:0] hidx;
  logic [CNT_W-1:0]  n_win;
  logic [CNT_W-1:0]  h_cnt;
  logic [CNT_W-1:0]  h_j;
  logic [SUM_W-1:0]  sum;
  logic [34:0]       cur_rate;
  logic [DVD_W-1:0]  dvd;
  logic [CNT_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;

  rec_t              flow_mem [FLOW_SLOTS];
  rec_t              flow_rd;
  logic [SLOT_W-1:0] flow_ra;
  logic [SLOT_W-1:0] flow_wa;
  logic              flow_we;
  rec_t              flow_wd;

  logic [31:0]        hist_mem [FLOW_SLOTS << HIST_W];
  logic [31:0]        hist_rd;
  logic [HADDR_W-1:0] hist_ra;
  logic [HADDR_W-1:0] hist_wa;
  logic               hist_we;
  logic [31:0]        hist_wd;

  rec_t              upd_rec;
  logic              upd_roll;
  rec_t              tick_rec;
  logic              tick_roll;
  rec_t              alloc_rec;
  frm_pkg::out_t     result;
  logic [32:0]       secb_sum;
  logic [CNT_W:0]    rem_sh;
  logic              tuple_hit;
  logic [39:0]       in_pp;

  function automatic rec_t roll(rec_t r);
    rec_t o;
    o = r;
    if ({r.secb, 3'b000} > r.peak) begin
      o.peak = {r.secb, 3'b000};
    end
    o.pos = (r.pos == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : r.pos + 1'b1;
    if (r.fill < CNT_W'(HISTORY_DEPTH)) begin
      o.fill = r.fill + 1'b1;
    end
    o.secb = '0;
    return o;
  endfunction

  assign in_ready = (state == IDLE);
  assign in_pp = {in_q.proto, in_q.l4_src, in_q.l4_dst};
  assign tuple_hit = (flow_rd.src == in_q.src_addr) && (flow_rd.dst == in_q.dst_addr) &&
                     (flow_rd.pp == in_pp);
  assign rem_sh = {rem, dvd[DVD_W-1]};

  always_comb begin
    upd_roll  = (in_q.now_second != rec.open_sec) && (rec.open_sec != '0);
    upd_rec   = upd_roll ? roll(rec) : rec;
    upd_rec.open_sec = in_q.now_second;
    upd_rec.bytes    = rec.bytes + 64'(in_q.pkt_length);
    upd_rec.pkts     = rec.pkts + 64'd1;
    secb_sum = {1'b0, upd_rec.secb} + 33'(in_q.pkt_length);
    upd_rec.secb = secb_sum[32] ? 32'hFFFF_FFFF : secb_sum[31:0];
    upd_rec.last = in_q.now_second;

    tick_roll = (flow_rd.open_sec != in_q.now_second) && (flow_rd.open_sec != '0);
    tick_rec  = roll(flow_rd);
    tick_rec.open_sec = in_q.now_second;

    alloc_rec     = '0;
    alloc_rec.src = in_q.src_addr;
    alloc_rec.dst = in_q.dst_addr;
    alloc_rec.pp  = in_pp;

    result = '0;
    result.status = status;
    if (status == frm_pkg::ST_UNUSED) begin
      result.slot = in_q.flow_slot;
    end
    if (stats_on) begin
      result.slot          = 10'(cur_slot);
      result.byte_count    = rec.bytes;
      result.pkt_count     = rec.pkts;
      result.rate_now_bps  = cur_rate;
      result.rate_peak_bps = rec.peak;
      result.avg_rate_bps  = (n_win == '0) ? 35'd0 : 35'(dvd);
      result.seen_sec      = rec.last;
    end

    flow_ra = idx;
    if (state == READ_RD) begin
      flow_ra = SLOT_W'(in_q.flow_slot);
    end
    flow_we = 1'b0;
    flow_wa = cur_slot;
    flow_wd = upd_rec;
    hist_we = 1'b0;
    hist_wa = {cur_slot, rec.pos};
    hist_wd = rec.secb;
    case (state)
      UPD: begin
        flow_we = 1'b1;
        hist_we = upd_roll;
      end
      TICK_EV: begin
        flow_we = tick_roll;
        flow_wa = idx;
        flow_wd = tick_rec;
        hist_we = tick_roll;
        hist_wa = {idx, flow_rd.pos};
        hist_wd = flow_rd.secb;
      end
      default: begin
      end
    endcase
    hist_ra = {cur_slot, hidx};
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_wa] <= flow_wd;
    end
    flow_rd <= flow_mem[flow_ra];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      filter_on  <= 1'b0;
      local_addr <= '0;
      used_slots <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          frm_pkg::REG_FILTER_ON:  filter_on  <= cfg_data[0];
          frm_pkg::REG_LOCAL_ADDR: local_addr <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            in_q     <= in_data;
            idx      <= '0;
            stats_on <= 1'b0;
            case (in_data.op)
              frm_pkg::OP_PACKET: begin
                if (filter_on && (in_data.src_addr == local_addr ||
                                  in_data.dst_addr == local_addr)) begin
                  status <= frm_pkg::ST_FILTERED;
                  state  <= FIN;
                end else if (used_slots == '0) begin
                  state <= ALLOC;
                end else begin
                  state <= SRCH_RD;
                end
              end
              frm_pkg::OP_TICK: begin
                status <= frm_pkg::ST_TICK;
                state  <= (used_slots == '0) ? FIN : TICK_RD;
              end
              frm_pkg::OP_READ: begin
                if (CMP_W'(in_data.flow_slot) >= CMP_W'(used_slots) ||
                    CMP_W'(in_data.flow_slot) >= CMP_W'(FLOW_SLOTS)) begin
                  status <= frm_pkg::ST_UNUSED;
                  state  <= FIN;
                end else begin
                  status   <= frm_pkg::ST_READ_OK;
                  cur_slot <= SLOT_W'(in_data.flow_slot);
                  state    <= READ_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        SRCH_RD: state <= SRCH_EV;
        SRCH_EV: begin
          if (tuple_hit) begin
            rec      <= flow_rd;
            cur_slot <= idx;
            status   <= frm_pkg::ST_EXISTING;
            state    <= UPD;
          end else begin
            // oldest last-seen, lowest slot wins a tie
            if (idx == '0 || flow_rd.last < min_last) begin
              min_last <= flow_rd.last;
              min_slot <= idx;
            end
            if (USED_W'(idx) + 1'b1 == used_slots) begin
              state <= ALLOC;
            end else begin
              idx   <= idx + 1'b1;
              state <= SRCH_RD;
            end
          end
        end
        ALLOC: begin
          if (used_slots < USED_W'(FLOW_SLOTS)) begin
            cur_slot   <= SLOT_W'(used_slots);
            used_slots <= used_slots + 1'b1;
            status     <= frm_pkg::ST_NEW;
          end else begin
            cur_slot <= min_slot;
            status   <= frm_pkg::ST_EVICTED;
          end
          rec   <= alloc_rec;
          state <= UPD;
        end
        UPD: begin
          rec   <= upd_rec;
          state <= RPT_SET;
        end
        TICK_RD: state <= TICK_EV;
        TICK_EV: begin
          if (USED_W'(idx) + 1'b1 == used_slots) begin
            state <= FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= TICK_RD;
          end
        end
        READ_RD: state <= READ_EV;
        READ_EV: begin
          rec   <= flow_rd;
          state <= RPT_SET;
        end
        RPT_SET: begin
          stats_on <= 1'b1;
          hidx     <= (rec.pos == '0) ? HIST_W'(HISTORY_DEPTH - 1) : rec.pos - 1'b1;
          sum      <= '0;
          cur_rate <= '0;
          h_j      <= '0;
          if (7'(in_q.window) > 7'(rec.fill)) begin
            n_win <= rec.fill;
            h_cnt <= rec.fill;
          end else begin
            n_win <= CNT_W'(in_q.window);
            // the newest entry is still read for the current rate
            h_cnt <= (in_q.window == '0) ? CNT_W'(rec.fill != '0) : CNT_W'(in_q.window);
          end
          if (rec.fill == '0) begin
            state <= DIV_SET;
          end else begin
            state <= HIST_RD;
          end
        end
        HIST_RD: state <= HIST_EV;
        HIST_EV: begin
          if (h_j == '0) begin
            cur_rate <= {hist_rd, 3'b000};
          end
          if (h_j < n_win) begin
            sum <= sum + SUM_W'(hist_rd);
          end
          hidx <= (hidx == '0) ? HIST_W'(HISTORY_DEPTH - 1) : hidx - 1'b1;
          h_j  <= h_j + 1'b1;
          state <= (h_j + 1'b1 == h_cnt) ? DIV_SET : HIST_RD;
        end
        DIV_SET: begin
          dvd  <= {sum, 3'b000};
          rem  <= '0;
          dcnt <= '0;
          state <= (n_win == '0) ? FIN : DIV;
        end
        DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem_sh >= {1'b0, n_win}) begin
            rem <= CNT_W'(rem_sh - {1'b0, n_win});
            dvd <= {dvd[DVD_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[CNT_W-1:0];
            dvd <= {dvd[DVD_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DVD_W - 1)) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (!out_valid || out_ready) begin
            out_data <= result;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
